FILE: sv/snfe_pkg.sv
// Shared types and constants of the spectrum noise floor estimator.
// No dependencies; imported by the top level and its checker.
package snfe_pkg;

   localparam int BIN_W      = 16;
   localparam int THR_W      = 15;
   localparam int SIZE_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;
   localparam int EDGE_W     = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FFT_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD   = 1'b1;

   localparam logic [SIZE_W-1:0] FFT_SIZE_RESET = 4'd10;
   localparam logic [THR_W-1:0]  SPREAD_RESET   = 15'd256;

   typedef logic [EDGE_W-1:0] bin_edge_type;

   typedef struct packed {
      bin_edge_type lo_end;
      bin_edge_type hi_start;
      bin_edge_type frame_end;
   } guard_type;

   // Guard band edges: N/2 - N/5, N/2 + N/5 and N, with the size saturated to 5..12.
   function automatic guard_type guard_band(input logic [SIZE_W-1:0] size_log2);
      guard_type g;
      case (size_log2)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: g = '{17'd10, 17'd22, 17'd32};
         4'd6:    g = '{17'd20, 17'd44, 17'd64};
         4'd7:    g = '{17'd39, 17'd89, 17'd128};
         4'd8:    g = '{17'd77, 17'd179, 17'd256};
         4'd9:    g = '{17'd154, 17'd358, 17'd512};
         4'd10:   g = '{17'd308, 17'd716, 17'd1024};
         4'd11:   g = '{17'd615, 17'd1433, 17'd2048};
         default: g = '{17'd1229, 17'd2867, 17'd4096};
      endcase
      return g;
   endfunction

endpackage

FILE: sv/snfe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module snfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/spectrum_noise_floor_estimator.sv
// Top level of the spectrum noise floor estimator.
// Depends on snfe_pkg and snfe_ram (history memory).

// The block takes one spectrum bin per request (start high while busy is low) and answers
// every bin flagged last_bin with one result, shown for a single cycle with rsp_valid high;
// the receiver cannot stall it, so results must be taken when they appear. A bin that does
// not end a frame leaves busy low. The bin that ends a normal frame
// starts a pass over the history memory, which has one read port: it sums every history,
// tests each mean against the average and, once the floor is valid, does the rounding
// division, which is done by a multiplication with the reciprocal of the constant divisor.
// The bin that ends a successful reselect frame starts a pass that seeds the first history
// slot of each new bin; a reselect frame that found too few eligible bins seeds nothing.
// The history memory needs no clearing pass: a valid bit per entry, cleared by reset and
// by each reselection, makes an unwritten entry read as zero.
module spectrum_noise_floor_estimator
   import snfe_pkg::*;
#(
   parameter int MAX_BINS      = 4096,
   parameter int TRACKED_BINS  = 10,
   parameter int HISTORY_DEPTH = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [BIN_W-1:0] req_bin_power,
   input  logic                   req_last_bin,
   output logic                   rsp_valid,
   output logic signed [BIN_W-1:0] rsp_noise_level,
   output logic                   rsp_level_valid,
   output logic                   rsp_reselect_next,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int PW     = $clog2(MAX_BINS);
   localparam int DEPTH  = TRACKED_BINS * HISTORY_DEPTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int KW     = $clog2(TRACKED_BINS);
   localparam int SW     = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(TRACKED_BINS + 1);
   localparam int CW     = BIN_W + $clog2(DEPTH) + 4;
   localparam int RW     = CW + 1;
   localparam int RECIP_S = CW + $clog2(2 * DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_DEV  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_SEED = 3'd4;
   localparam logic [2:0] ST_DROP = 3'd5;

   localparam logic signed [CW-1:0] TRACKED_C = CW'(TRACKED_BINS);
   localparam logic signed [CW-1:0] DEPTH_C   = CW'(DEPTH);
   localparam logic [CW-1:0]        DIVISOR_C = CW'(2 * DEPTH);
   // Rounded-up reciprocal of the divisor; exact for every dividend below 2**CW.
   localparam logic [RW-1:0]        RECIP_C   =
      RW'(((64'd1 << RECIP_S) + 64'(2 * DEPTH) - 64'd1) / 64'(2 * DEPTH));

   // Control state.
   logic [2:0]          state_ff, state_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DEPTH-1:0]    hv_ff, hv_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic                ready_ff, ready_in;
   logic                resel_ff, resel_in;
   logic signed [BIN_W-1:0] floor_ff, floor_in;
   logic [AW-1:0]       ra_ff, ra_in;
   logic                issue_done_ff, issue_done_in;
   logic                rv_ff, rv_in;
   logic [SW-1:0]       dj_ff, dj_in;
   logic [KW-1:0]       dk_ff, dk_in;
   logic                spread_ff, spread_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic signed [BIN_W-1:0] lev_ff [TRACKED_BINS];
   logic signed [BIN_W-1:0] lev_in [TRACKED_BINS];
   logic [PW-1:0]       bins_ff [TRACKED_BINS];
   logic [PW-1:0]       bins_in [TRACKED_BINS];
   logic signed [CW-1:0] sums_ff [TRACKED_BINS];
   logic signed [CW-1:0] sums_in [TRACKED_BINS];
   logic                rvalid_ff, rvalid_in;
   logic signed [CW-1:0] row_ff, row_in;
   logic signed [CW-1:0] total_ff, total_in;
   logic [CW-1:0]       dvd_ff, dvd_in;
   logic                neg_ff, neg_in;

   // Memory port signals.
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [BIN_W-1:0]    wr_data;
   logic                rd_en;
   logic [BIN_W-1:0]    rd_data;

   // Datapath helpers.
   logic                accept;
   guard_type           guard;
   bin_edge_type        p_ext;
   logic                eligible;
   logic [TRACKED_BINS-1:0] lt;
   logic [TRACKED_BINS-1:0] hit;
   logic [KW-1:0]       hit_idx;
   logic [CNT_W-1:0]    cnt_next;
   logic signed [CW-1:0] rd_val;
   logic signed [CW-1:0] row_sum;
   logic signed [CW-1:0] dev;
   logic signed [CW-1:0] dev_abs;
   logic signed [CW-1:0] limit;
   logic                spread_now;
   logic                ready_next;
   logic signed [CW-1:0] num;
   logic [CW+RW-1:0]    prod;
   logic [CW-1:0]       quo;

   assign busy              = (state_ff != ST_IDLE);
   assign accept            = start && !busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_noise_level   = floor_ff;
   assign rsp_level_valid   = ready_ff;
   assign rsp_reselect_next = resel_ff;

   assign guard    = guard_band(size_ff);
   assign p_ext    = EDGE_W'(pos_ff);
   assign eligible = ((p_ext >= bin_edge_type'(1)) && (p_ext < guard.lo_end)) ||
                     ((p_ext >= guard.hi_start) && (p_ext < guard.frame_end));

   // Candidates are kept sorted; lt marks the prefix that stays ahead of the new bin.
   always_comb begin
      for (int i = 0; i < TRACKED_BINS; i++) begin
         lt[i]  = (CNT_W'(i) < cnt_ff) && (lev_ff[i] <= req_bin_power);
         hit[i] = (bins_ff[i] == pos_ff);
      end
      hit_idx = '0;
      for (int i = 0; i < TRACKED_BINS; i++) begin
         if (hit[i]) begin
            hit_idx = KW'(i);
         end
      end
   end

   assign limit = $signed(CW'(thr_ff)) * DEPTH_C;

   snfe_ram #(
      .WIDTH(BIN_W),
      .DEPTH(DEPTH)
   ) u_history (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(ra_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      thr_in        = thr_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      hv_in         = hv_ff;
      slot_in       = slot_ff;
      ready_in      = ready_ff;
      resel_in      = resel_ff;
      floor_in      = floor_ff;
      ra_in         = ra_ff;
      issue_done_in = issue_done_ff;
      rv_in         = 1'b0;
      dj_in         = dj_ff;
      dk_in         = dk_ff;
      spread_in     = spread_ff;
      rsp_valid_in  = 1'b0;
      lev_in        = lev_ff;
      bins_in       = bins_ff;
      sums_in       = sums_ff;
      rvalid_in     = rvalid_ff;
      row_in        = row_ff;
      total_in      = total_ff;
      dvd_in        = dvd_ff;
      neg_in        = neg_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = req_bin_power;
      rd_en         = 1'b0;
      cnt_next      = cnt_ff;
      rd_val        = '0;
      row_sum       = '0;
      dev           = '0;
      dev_abs       = '0;
      spread_now    = spread_ff;
      ready_next    = ready_ff;
      num           = '0;
      prod          = '0;
      quo           = '0;

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FFT_SIZE: size_in = csr_wr_data[SIZE_W-1:0];
            CSR_SPREAD:   thr_in  = csr_wr_data[THR_W-1:0];
            default:      ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (resel_ff) begin
                  if (eligible && !lt[TRACKED_BINS-1]) begin
                     for (int i = 0; i < TRACKED_BINS; i++) begin
                        if (!lt[i]) begin
                           if (i == 0 || lt[(i == 0) ? 0 : i - 1]) begin
                              lev_in[i]  = req_bin_power;
                              bins_in[i] = pos_ff;
                           end else begin
                              lev_in[i]  = lev_ff[(i == 0) ? 0 : i - 1];
                              bins_in[i] = bins_ff[(i == 0) ? 0 : i - 1];
                           end
                        end
                     end
                     if (cnt_ff != CNT_W'(TRACKED_BINS)) begin
                        cnt_next = cnt_ff + CNT_W'(1);
                     end
                  end
                  cnt_in = cnt_next;
               end else if (|hit) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(32'(hit_idx) * HISTORY_DEPTH + 32'(slot_ff));
                  hv_in[wr_addr] = 1'b1;
               end
               if (req_last_bin) begin
                  pos_in = '0;
                  cnt_in = '0;
                  if (resel_ff) begin
                     if (cnt_next == CNT_W'(TRACKED_BINS)) begin
                        // New bins chosen: drop all history and seed slot zero.
                        hv_in    = '0;
                        resel_in = 1'b0;
                        ready_in = 1'b0;
                        slot_in  = SW'(1 % HISTORY_DEPTH);
                        dk_in    = '0;
                        state_in = ST_SEED;
                     end else begin
                        state_in = ST_DROP;
                     end
                  end else begin
                     ra_in         = '0;
                     issue_done_in = 1'b0;
                     dj_in         = '0;
                     dk_in         = '0;
                     row_in        = '0;
                     total_in      = '0;
                     state_in      = ST_SUM;
                  end
               end else if (pos_ff != PW'(MAX_BINS - 1)) begin
                  pos_in = pos_ff + PW'(1);
               end
            end
         end

         ST_SUM: begin
            if (!issue_done_ff) begin
               rd_en     = 1'b1;
               rv_in     = 1'b1;
               rvalid_in = hv_ff[ra_ff];
               if (ra_ff == AW'(DEPTH - 1)) begin
                  issue_done_in = 1'b1;
               end else begin
                  ra_in = ra_ff + AW'(1);
               end
            end
            if (rv_ff) begin
               rd_val  = rvalid_ff ? CW'($signed(rd_data)) : '0;
               row_sum = row_ff + rd_val;
               if (dj_ff == SW'(HISTORY_DEPTH - 1)) begin
                  sums_in[dk_ff] = row_sum;
                  total_in       = total_ff + row_sum;
                  row_in         = '0;
                  dj_in          = '0;
                  if (dk_ff == KW'(TRACKED_BINS - 1)) begin
                     dk_in     = '0;
                     spread_in = 1'b0;
                     state_in  = ST_DEV;
                  end else begin
                     dk_in = dk_ff + KW'(1);
                  end
               end else begin
                  row_in = row_sum;
                  dj_in  = dj_ff + SW'(1);
               end
            end
         end

         ST_DEV: begin
            dev        = TRACKED_C * sums_ff[dk_ff] - total_ff;
            dev_abs    = dev[CW-1] ? -dev : dev;
            spread_now = spread_ff || (dev_abs >= limit);
            spread_in  = spread_now;
            if (dk_ff == KW'(TRACKED_BINS - 1)) begin
               resel_in   = resel_ff || spread_now;
               ready_next = ready_ff || (slot_ff == SW'(HISTORY_DEPTH - 1));
               ready_in   = ready_next;
               slot_in    = (slot_ff == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + SW'(1);
               if (ready_next) begin
                  // Floor division of 2*total + D by 2*D, done on the magnitude.
                  num     = (total_ff <<< 1) + DEPTH_C;
                  neg_in  = num[CW-1];
                  dvd_in  = num[CW-1] ? CW'(-num + $signed(DIVISOR_C) - CW'(1)) : CW'(num);
                  state_in = ST_DIV;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               dk_in = dk_ff + KW'(1);
            end
         end

         ST_DIV: begin
            prod         = (CW+RW)'(dvd_ff) * (CW+RW)'(RECIP_C);
            quo          = CW'(prod >> RECIP_S);
            floor_in     = neg_ff ? BIN_W'(-$signed(quo)) : BIN_W'(quo);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_SEED: begin
            wr_en   = 1'b1;
            wr_addr = AW'(32'(dk_ff) * HISTORY_DEPTH);
            wr_data = lev_ff[dk_ff];
            hv_in[wr_addr] = 1'b1;
            if (dk_ff == KW'(TRACKED_BINS - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               dk_in = dk_ff + KW'(1);
            end
         end

         ST_DROP: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         size_ff       <= FFT_SIZE_RESET;
         thr_ff        <= SPREAD_RESET;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         hv_ff         <= '0;
         slot_ff       <= '0;
         ready_ff      <= 1'b0;
         resel_ff      <= 1'b1;
         floor_ff      <= '0;
         ra_ff         <= '0;
         issue_done_ff <= 1'b0;
         rv_ff         <= 1'b0;
         dj_ff         <= '0;
         dk_ff         <= '0;
         spread_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         thr_ff        <= thr_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         hv_ff         <= hv_in;
         slot_ff       <= slot_in;
         ready_ff      <= ready_in;
         resel_ff      <= resel_in;
         floor_ff      <= floor_in;
         ra_ff         <= ra_in;
         issue_done_ff <= issue_done_in;
         rv_ff         <= rv_in;
         dj_ff         <= dj_in;
         dk_ff         <= dk_in;
         spread_ff     <= spread_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lev_ff    <= lev_in;
      bins_ff   <= bins_in;
      sums_ff   <= sums_in;
      rvalid_ff <= rvalid_in;
      row_ff    <= row_in;
      total_ff  <= total_in;
      dvd_ff    <= dvd_in;
      neg_ff    <= neg_in;
   end

endmodule

FILE: sv/snfe_checker.sv
// Port-level assertions for the spectrum noise floor estimator, bound to the top level.
// Depends on snfe_pkg and spectrum_noise_floor_estimator.
module snfe_port_checker
   import snfe_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_bin,
   input logic rsp_valid
);

   // A request that ends a frame always makes the block busy.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_bin |=> busy)
      else $error("frame end did not raise busy");

   // A result is shown only while the block is idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Every end of a busy period delivers a result.
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy ended without a result");

   // Results never stand on two adjacent cycles.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind spectrum_noise_floor_estimator snfe_port_checker u_snfe_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_last_bin(req_last_bin),
   .rsp_valid   (rsp_valid)
);
